// ----- hw/rtl/rsch_pkg.sv -----
// ----------------------------------------------------------------------------
// rsch_pkg
// Shared constants and types of the ray/sphere closest-hit block.
// ----------------------------------------------------------------------------
package rsch_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int NORM_BITS     = 16;

  localparam logic [16:0] NORM_ONE = 17'h10000;
  localparam logic [5:0]  K_MAX    = 6'd32;

  localparam logic [1:0] CMD_ORIGIN = 2'd0;
  localparam logic [1:0] CMD_DIR    = 2'd1;
  localparam logic [1:0] CMD_SPHERE = 2'd2;

  // product groups of the serial multiplier
  typedef enum logic [2:0] {
    G_AA = 3'd0,
    G_B  = 3'd1,
    G_OO = 3'd2,
    G_RR = 3'd3,
    G_BB = 3'd4,
    G_AC = 3'd5,
    G_M  = 3'd6,
    G_VV = 3'd7
  } mgrp_t;

  typedef enum logic [16:0] {
    ST_IDLE  = 17'h00001,
    ST_OC    = 17'h00002,
    ST_MLD   = 17'h00004,
    ST_MUL   = 17'h00008,
    ST_DISC1 = 17'h00010,
    ST_DISC2 = 17'h00020,
    ST_SQRT  = 17'h00040,
    ST_ROOT0 = 17'h00080,
    ST_ROOT1 = 17'h00100,
    ST_DIV   = 17'h00200,
    ST_TCHK  = 17'h00400,
    ST_NZERO = 17'h00800,
    ST_KSCAN = 17'h01000,
    ST_NLD   = 17'h02000,
    ST_NCHK  = 17'h04000,
    ST_UPD   = 17'h08000,
    ST_OUT   = 17'h10000
  } state_t;

endpackage

// ----- hw/rtl/ray_sphere_closest_hit.sv -----
// ----------------------------------------------------------------------------
// ray_sphere_closest_hit
// Closest ray/sphere hit in fixed point with unit normal and albedo. A
// sphere test runs on one bit-serial multiplier (12 products before the
// roots and 6 more on a hit), a square root unit and a restoring divider
// that each produce one result bit a cycle, the distance divider's step
// count growing with FRAC_BITS. One item is in work at a time; in_stall is
// high while a sphere is tested, and a finished result waits in the output
// register while the next item is taken.
// ----------------------------------------------------------------------------
module ray_sphere_closest_hit import rsch_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         cmd,
  input  logic signed [31:0] vec_x,
  input  logic signed [31:0] vec_y,
  input  logic signed [31:0] vec_z,
  input  logic [30:0]        radius,
  input  logic [15:0]        alb_r,
  input  logic [15:0]        alb_g,
  input  logic [15:0]        alb_b,
  input  logic               last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               hit,
  output logic [31:0]        hit_dist,
  output logic signed [17:0] normal_x,
  output logic signed [17:0] normal_y,
  output logic signed [17:0] normal_z,
  output logic [15:0]        hit_r,
  output logic [15:0]        hit_g,
  output logic [15:0]        hit_b
);

  localparam logic [31:0] EPS_T      = 32'(((64'd1 << FRAC_BITS) + 64'd500) / 64'd1000);
  localparam logic [6:0]  DIST_STEPS = 7'(65 + FRAC_BITS);
  localparam logic [6:0]  NORM_STEPS = 7'(64 + NORM_BITS);
  localparam logic [63:0] ROUND_UP   = 64'((64'd1 << FRAC_BITS) - 64'd1);
  localparam logic [6:0]  MUL_STEPS  = 7'd64;
  localparam logic [6:0]  SQRT_STEPS = 7'd64;

  state_t state;

  logic [31:0]  org [3];
  logic [31:0]  dir [3];
  logic [31:0]  ctr [3];
  logic [31:0]  oc [3];
  logic [30:0]  rad;
  logic [15:0]  alb [3];
  logic         is_last;

  logic [63:0]  acc_a, acc_bp, acc_bn, acc_oo, r2, bm, cm, q;
  logic         bneg, cneg;
  logic [127:0] b2, sum;

  mgrp_t        grp;
  logic [1:0]   lane;
  logic [6:0]   cnt;

  logic [63:0]  mul_a, mul_b, mul_hi, mul_lo;

  logic [127:0] sq_x;
  logic [64:0]  sq_rem;
  logic [63:0]  sq_root;
  logic         sq_norm;
  logic [5:0]   k;

  logic [127:0] div_num;
  logic [63:0]  div_rem, div_d;
  logic [32:0]  div_quo;
  logic         div_ovf, div_norm, phase;

  logic [31:0]  t;
  logic         found;
  logic [63:0]  v [3];
  logic [17:0]  nrm [3];

  logic [31:0]  best_dist;
  logic [17:0]  best_nrm [3];
  logic [15:0]  best_alb [3];
  logic         any_hit;

  logic [31:0]  dm [3];
  logic [31:0]  om [3];
  logic [63:0]  vm [3];
  logic [63:0]  op_a, op_b;
  logic [64:0]  mul_sum;
  logic [127:0] product;
  logic [66:0]  sq_cur, sq_trial, sq_diff;
  logic         sq_ge;
  logic [64:0]  dv_cur;
  logic [65:0]  dv_diff;
  logic         dv_ge;
  logic [31:0]  t_val;
  logic [16:0]  nmag;
  logic [17:0]  nval;
  logic [63:0]  oc_ext, term_pos, term_neg, v_new;
  logic [64:0]  n_sub, n_add, n_qb;
  logic         in_take;

  function automatic logic [31:0] sat_sub(input logic [31:0] p, input logic [31:0] c);
    logic [32:0] d;
    d = {p[31], p} - {c[31], c};
    if (d[32] != d[31]) begin
      sat_sub = d[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      sat_sub = d[31:0];
    end
  endfunction

  assign in_stall = (state != ST_IDLE);
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dm[i] = dir[i][31] ? 32'd0 - dir[i] : dir[i];
      om[i] = oc[i][31] ? 32'd0 - oc[i] : oc[i];
      vm[i] = v[i][63] ? 64'd0 - v[i] : v[i];
    end
  end

  // multiplier operands per product group
  always_comb begin
    case (grp)
      G_AA: begin
        op_a = {32'd0, dm[lane]};
        op_b = {32'd0, dm[lane]};
      end
      G_B: begin
        op_a = {32'd0, om[lane]};
        op_b = {32'd0, dm[lane]};
      end
      G_OO: begin
        op_a = {32'd0, om[lane]};
        op_b = {32'd0, om[lane]};
      end
      G_RR: begin
        op_a = {33'd0, rad};
        op_b = {33'd0, rad};
      end
      G_BB: begin
        op_a = bm;
        op_b = bm;
      end
      G_AC: begin
        op_a = acc_a;
        op_b = cm;
      end
      G_M: begin
        op_a = {32'd0, dm[lane]};
        op_b = {32'd0, t};
      end
      G_VV: begin
        op_a = vm[lane];
        op_b = vm[lane];
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign mul_sum = {1'b0, mul_hi} + (mul_b[0] ? {1'b0, mul_a} : 65'd0);
  assign product = {mul_hi, mul_lo};

  assign sq_cur   = {sq_rem, sq_x[127:126]};
  assign sq_trial = {1'b0, sq_root, 2'b01};
  assign sq_ge    = (sq_cur >= sq_trial);
  assign sq_diff  = sq_cur - sq_trial;

  assign dv_cur  = {div_rem, div_num[127]};
  assign dv_diff = {1'b0, dv_cur} - {2'b00, div_d};
  assign dv_ge   = !dv_diff[65];

  assign t_val = (div_ovf || div_quo[32]) ? 32'hFFFF_FFFF : div_quo[31:0];
  assign nmag  = (div_ovf || (div_quo > {16'd0, NORM_ONE})) ? NORM_ONE : div_quo[16:0];
  assign nval  = v[lane][63] ? 18'd0 - {1'b0, nmag} : {1'b0, nmag};

  // point on the sphere relative to its center
  assign oc_ext   = {{32{oc[lane][31]}}, oc[lane]};
  assign term_pos = mul_lo >> FRAC_BITS;
  assign term_neg = (mul_lo + ROUND_UP) >> FRAC_BITS;
  assign v_new    = dir[lane][31] ? oc_ext - term_neg : oc_ext + term_pos;

  assign n_sub = {1'b0, bm - q};
  assign n_add = {1'b0, bm} + {1'b0, q};
  assign n_qb  = {1'b0, q - bm};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      any_hit   <= 1'b0;
      best_dist <= '1;
      for (int i = 0; i < 3; i++) begin
        org[i]      <= '0;
        dir[i]      <= '0;
        best_nrm[i] <= '0;
        best_alb[i] <= '0;
      end
    end else begin
      if (out_valid && !out_stall && state != ST_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_take) begin
            case (cmd)
              CMD_ORIGIN: begin
                org[0]    <= vec_x;
                org[1]    <= vec_y;
                org[2]    <= vec_z;
                any_hit   <= 1'b0;
                best_dist <= '1;
                for (int i = 0; i < 3; i++) begin
                  best_nrm[i] <= '0;
                  best_alb[i] <= '0;
                end
              end
              CMD_DIR: begin
                dir[0] <= vec_x;
                dir[1] <= vec_y;
                dir[2] <= vec_z;
              end
              CMD_SPHERE: begin
                ctr[0]  <= vec_x;
                ctr[1]  <= vec_y;
                ctr[2]  <= vec_z;
                rad     <= radius;
                alb[0]  <= alb_r;
                alb[1]  <= alb_g;
                alb[2]  <= alb_b;
                is_last <= last;
                state   <= ST_OC;
              end
              default: begin
              end
            endcase
          end
        end
        ST_OC: begin
          for (int i = 0; i < 3; i++) begin
            oc[i] <= sat_sub(org[i], ctr[i]);
          end
          acc_a  <= '0;
          acc_bp <= '0;
          acc_bn <= '0;
          acc_oo <= '0;
          found  <= 1'b0;
          grp    <= G_AA;
          lane   <= '0;
          state  <= ST_MLD;
        end
        ST_MLD: begin
          mul_a  <= op_a;
          mul_b  <= op_b;
          mul_hi <= '0;
          cnt    <= MUL_STEPS;
          state  <= ST_MUL;
        end
        ST_MUL: begin
          if (cnt != '0) begin
            mul_hi <= mul_sum[64:1];
            mul_lo <= {mul_sum[0], mul_lo[63:1]};
            mul_b  <= mul_b >> 1;
            cnt    <= cnt - 7'd1;
          end else begin
            case (grp)
              G_AA: acc_a <= acc_a + mul_lo;
              G_B: begin
                if (oc[lane][31] != dir[lane][31]) begin
                  acc_bn <= acc_bn + mul_lo;
                end else begin
                  acc_bp <= acc_bp + mul_lo;
                end
              end
              G_OO: acc_oo <= acc_oo + mul_lo;
              G_RR: r2 <= mul_lo;
              G_BB: b2 <= product;
              G_M:  v[lane] <= v_new;
              G_VV: sum <= sum + product;
              default: begin
              end
            endcase
            if ((grp == G_AA || grp == G_B || grp == G_OO || grp == G_M || grp == G_VV)
                && lane != 2'd2) begin
              lane  <= lane + 2'd1;
              state <= ST_MLD;
            end else begin
              lane <= '0;
              case (grp)
                G_AA: begin
                  grp   <= G_B;
                  state <= ST_MLD;
                end
                G_B: begin
                  grp   <= G_OO;
                  state <= ST_MLD;
                end
                G_OO: begin
                  grp   <= G_RR;
                  state <= ST_MLD;
                end
                G_RR: state <= ST_DISC1;
                G_BB: begin
                  grp   <= G_AC;
                  state <= ST_MLD;
                end
                G_AC: state <= ST_DISC2;
                G_M: begin
                  grp   <= G_VV;
                  state <= ST_MLD;
                end
                G_VV: state <= ST_NZERO;
                default: state <= ST_IDLE;
              endcase
            end
          end
        end
        ST_DISC1: begin
          bneg  <= (acc_bn > acc_bp);
          bm    <= (acc_bn > acc_bp) ? acc_bn - acc_bp : acc_bp - acc_bn;
          cneg  <= (r2 > acc_oo);
          cm    <= (r2 > acc_oo) ? r2 - acc_oo : acc_oo - r2;
          grp   <= G_BB;
          lane  <= '0;
          state <= ST_MLD;
        end
        ST_DISC2: begin
          sq_rem  <= '0;
          sq_root <= '0;
          sq_norm <= 1'b0;
          cnt     <= SQRT_STEPS;
          if (acc_a == '0) begin
            state <= ST_UPD;
          end else if (cneg) begin
            sq_x  <= b2 + product;
            state <= ST_SQRT;
          end else if (b2 < product) begin
            state <= ST_UPD;
          end else begin
            sq_x  <= b2 - product;
            state <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          if (cnt != '0) begin
            sq_x <= sq_x << 2;
            if (sq_ge) begin
              sq_rem  <= sq_diff[64:0];
              sq_root <= {sq_root[62:0], 1'b1};
            end else begin
              sq_rem  <= sq_cur[64:0];
              sq_root <= {sq_root[62:0], 1'b0};
            end
            cnt <= cnt - 7'd1;
          end else if (!sq_norm) begin
            q     <= sq_root;
            state <= ST_ROOT0;
          end else begin
            div_d <= sq_root;
            lane  <= '0;
            state <= ST_NLD;
          end
        end
        ST_ROOT0: begin
          phase <= 1'b0;
          if (bneg && bm > q) begin
            div_num  <= {n_sub, 63'd0};
            div_rem  <= '0;
            div_quo  <= '0;
            div_ovf  <= 1'b0;
            div_d    <= acc_a;
            div_norm <= 1'b0;
            cnt      <= DIST_STEPS;
            state    <= ST_DIV;
          end else begin
            state <= ST_ROOT1;
          end
        end
        ST_ROOT1: begin
          phase    <= 1'b1;
          div_rem  <= '0;
          div_quo  <= '0;
          div_ovf  <= 1'b0;
          div_d    <= acc_a;
          div_norm <= 1'b0;
          cnt      <= DIST_STEPS;
          if (bneg) begin
            div_num <= {n_add, 63'd0};
            state   <= ST_DIV;
          end else if (q > bm) begin
            div_num <= {n_qb, 63'd0};
            state   <= ST_DIV;
          end else begin
            state <= ST_UPD;
          end
        end
        ST_DIV: begin
          if (cnt != '0) begin
            div_num <= div_num << 1;
            div_rem <= dv_ge ? dv_diff[63:0] : dv_cur[63:0];
            div_ovf <= div_ovf | div_quo[32];
            div_quo <= {div_quo[31:0], dv_ge};
            cnt     <= cnt - 7'd1;
          end else begin
            state <= div_norm ? ST_NCHK : ST_TCHK;
          end
        end
        ST_TCHK: begin
          if (t_val > EPS_T) begin
            t     <= t_val;
            found <= 1'b1;
            sum   <= '0;
            grp   <= G_M;
            lane  <= '0;
            state <= ST_MLD;
          end else if (!phase) begin
            state <= ST_ROOT1;
          end else begin
            state <= ST_UPD;
          end
        end
        ST_NZERO: begin
          if (sum == '0) begin
            nrm[0] <= '0;
            nrm[1] <= {1'b0, NORM_ONE};
            nrm[2] <= '0;
            state  <= ST_UPD;
          end else begin
            sq_x  <= sum;
            k     <= '0;
            state <= ST_KSCAN;
          end
        end
        ST_KSCAN: begin
          if (k < K_MAX && sq_x[125:124] == 2'b00) begin
            sq_x <= sq_x << 2;
            k    <= k + 6'd2;
          end else begin
            sq_rem  <= '0;
            sq_root <= '0;
            sq_norm <= 1'b1;
            cnt     <= SQRT_STEPS;
            state   <= ST_SQRT;
          end
        end
        ST_NLD: begin
          div_num  <= {vm[lane], 64'd0};
          div_rem  <= '0;
          div_quo  <= '0;
          div_ovf  <= 1'b0;
          div_norm <= 1'b1;
          cnt      <= NORM_STEPS + {2'b00, k[5:1]};
          state    <= ST_DIV;
        end
        ST_NCHK: begin
          nrm[lane] <= nval;
          if (lane == 2'd2) begin
            state <= ST_UPD;
          end else begin
            lane  <= lane + 2'd1;
            state <= ST_NLD;
          end
        end
        ST_UPD: begin
          if (found && (!any_hit || t < best_dist)) begin
            any_hit   <= 1'b1;
            best_dist <= t;
            for (int i = 0; i < 3; i++) begin
              best_nrm[i] <= nrm[i];
              best_alb[i] <= alb[i];
            end
          end
          state <= is_last ? ST_OUT : ST_IDLE;
        end
        ST_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            hit       <= any_hit;
            hit_dist  <= any_hit ? best_dist : '0;
            normal_x  <= any_hit ? best_nrm[0] : '0;
            normal_y  <= any_hit ? best_nrm[1] : '0;
            normal_z  <= any_hit ? best_nrm[2] : '0;
            hit_r     <= any_hit ? best_alb[0] : '0;
            hit_g     <= any_hit ? best_alb[1] : '0;
            hit_b     <= any_hit ? best_alb[2] : '0;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_sphere_start: assert property (@(posedge clk) disable iff (rst)
    in_take && cmd == CMD_SPHERE |=> state == ST_OC)
    else $error("sphere transfer did not start a test");

  a_origin_clear: assert property (@(posedge clk) disable iff (rst)
    in_take && cmd == CMD_ORIGIN |=> !any_hit && best_dist == 32'hFFFF_FFFF)
    else $error("origin load did not clear the kept hit");

  a_no_hit_inf: assert property (@(posedge clk) disable iff (rst)
    !any_hit |-> best_dist == 32'hFFFF_FFFF)
    else $error("kept distance set without a hit");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> div_rem < div_d)
    else $error("divider remainder out of range");

  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_OUT))
    else $error("result shown outside of output state");
`endif

endmodule
